FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked on every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: src/mrrb_pkg.sv
package mrrb_pkg;

    localparam logic [3:0] OP_PUSH_BYTE = 4'd0;
    localparam logic [3:0] OP_PUSH_HALF = 4'd1;
    localparam logic [3:0] OP_PULL_BYTE = 4'd2;
    localparam logic [3:0] OP_PULL_HALF = 4'd3;
    localparam logic [3:0] OP_SKIP      = 4'd4;
    localparam logic [3:0] OP_OPEN      = 4'd5;
    localparam logic [3:0] OP_CLOSE     = 4'd6;
    localparam logic [3:0] OP_CLEAR     = 4'd7;
    localparam logic [3:0] OP_QUERY     = 4'd8;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_OVER   = 2'd1;
    localparam logic [1:0] ST_UNDER  = 2'd2;
    localparam logic [1:0] ST_CLOSED = 2'd3;

    localparam logic [2:0]  REG_RING_BYTES = 3'd0;
    localparam logic [12:0] RING_BYTES_RST = 13'd4096;

    // wide enough for any ring offset or ring size
    typedef logic [16:0] t_ptr;

    typedef struct packed {
        logic [1:0] status;
        logic       push_ok;
        logic       push_two;
        logic       pull_ok;
        logic       pull_half;
    } t_exec_info;

    typedef struct packed {
        logic [11:0] fill;
        logic [11:0] max_fill;
        logic        is_open;
    } t_view;

    function automatic t_ptr ring_inc(input t_ptr a, input t_ptr size);
        t_ptr t;
        t = a + t_ptr'(1);
        if (t >= size) begin
            t = '0;
        end
        return t;
    endfunction

endpackage

FILE: src/mrrb_ram.sv
module mrrb_ram #(
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [7:0]               i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [7:0]               o_rdata_a,
    output logic [7:0]               o_rdata_b
);

    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

FILE: src/mrrb_state.sv
module mrrb_state #(
    parameter int RING_DEPTH = 4096,
    parameter int READERS    = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(RING_DEPTH):0]   i_size,
    input  logic                          i_exec,
    input  logic                          i_empty,
    input  logic [3:0]                    i_op,
    input  logic [1:0]                    i_reader,
    input  logic [11:0]                   i_count,
    output mrrb_pkg::t_exec_info          o_info,
    output logic [$clog2(RING_DEPTH)-1:0] o_wr_addr0,
    output logic [$clog2(RING_DEPTH)-1:0] o_wr_addr1,
    output logic [$clog2(RING_DEPTH)-1:0] o_rd_base,
    output mrrb_pkg::t_view               o_view,
    output logic [$clog2(RING_DEPTH)-1:0] o_fill_full
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int BW = AW + 1;
    localparam int RW = (READERS > 1) ? $clog2(READERS) : 1;
    localparam int SW = ((AW > 12) ? AW : 12) + 1;

    logic [AW-1:0]      r_w;
    logic [AW-1:0]      r_rp   [READERS];
    logic [READERS-1:0] r_open;
    logic [AW-1:0]      n_w;
    logic [AW-1:0]      n_rp   [READERS];
    logic [READERS-1:0] n_open;

    logic [AW-1:0] fill_all [READERS];
    logic [AW-1:0] max_fill;
    logic          over;
    logic [1:0]    n_push;
    logic [RW-1:0] idx;
    logic          rd_valid;
    logic          cur_open;
    logic [AW-1:0] cur_p;
    logic [AW-1:0] cur_fill;
    logic [11:0]   n_amt;
    logic          under;
    logic [SW-1:0] adv_sum;
    logic [AW-1:0] p_adv;
    logic          is_push;
    logic          is_rd_op;
    logic          rd_ok;
    logic [AW-1:0] p_after;
    logic [AW-1:0] w1;
    logic [AW-1:0] w2;

    assign idx      = RW'(i_reader);
    assign rd_valid = (32'(i_reader) < READERS);
    assign cur_open = rd_valid && r_open[idx];
    assign cur_p    = rd_valid ? r_rp[idx] : '0;
    assign cur_fill = cur_open ? fill_all[idx] : '0;

    assign w1 = AW'(mrrb_pkg::ring_inc(mrrb_pkg::t_ptr'(r_w), mrrb_pkg::t_ptr'(i_size)));
    assign w2 = AW'(mrrb_pkg::ring_inc(mrrb_pkg::t_ptr'(w1), mrrb_pkg::t_ptr'(i_size)));

    always_comb begin
        over     = 1'b0;
        max_fill = '0;
        n_push   = (i_op == mrrb_pkg::OP_PUSH_HALF) ? 2'd2 : 2'd1;
        for (int i = 0; i < READERS; i++) begin
            if (r_open[i]) begin
                fill_all[i] = AW'(BW'(r_w) + ((r_w >= r_rp[i]) ? BW'(0) : i_size)
                                  - BW'(r_rp[i]));
            end else begin
                fill_all[i] = '0;
            end
            if (r_open[i] && ((BW'(fill_all[i]) + BW'(n_push) + BW'(2)) > i_size)) begin
                over = 1'b1;
            end
            if (fill_all[i] > max_fill) begin
                max_fill = fill_all[i];
            end
        end
    end

    always_comb begin
        case (i_op)
            mrrb_pkg::OP_PULL_BYTE: n_amt = 12'd1;
            mrrb_pkg::OP_PULL_HALF: n_amt = 12'd2;
            default:                n_amt = i_count;
        endcase
        under   = SW'(n_amt) > SW'(cur_fill);
        adv_sum = SW'(cur_p) + SW'(n_amt);
        if (adv_sum >= SW'(i_size)) begin
            p_adv = AW'(adv_sum - SW'(i_size));
        end else begin
            p_adv = AW'(adv_sum);
        end
    end

    always_comb begin
        is_push  = (i_op == mrrb_pkg::OP_PUSH_BYTE) || (i_op == mrrb_pkg::OP_PUSH_HALF);
        is_rd_op = (i_op == mrrb_pkg::OP_PULL_BYTE) || (i_op == mrrb_pkg::OP_PULL_HALF)
                   || (i_op == mrrb_pkg::OP_SKIP);
        rd_ok    = is_rd_op && cur_open && !under;

        o_info.push_ok   = is_push && !over;
        o_info.push_two  = (i_op == mrrb_pkg::OP_PUSH_HALF);
        o_info.pull_ok   = rd_ok && (i_op != mrrb_pkg::OP_SKIP);
        o_info.pull_half = (i_op == mrrb_pkg::OP_PULL_HALF);
        if (is_push && over) begin
            o_info.status = mrrb_pkg::ST_OVER;
        end else if (is_rd_op && !cur_open) begin
            o_info.status = mrrb_pkg::ST_CLOSED;
        end else if (is_rd_op && under) begin
            o_info.status = mrrb_pkg::ST_UNDER;
        end else begin
            o_info.status = mrrb_pkg::ST_OK;
        end

        n_w    = r_w;
        n_open = r_open;
        for (int i = 0; i < READERS; i++) begin
            n_rp[i] = r_rp[i];
        end
        p_after = cur_p;

        if (i_empty) begin
            n_w = '0;
            for (int i = 0; i < READERS; i++) begin
                if (r_open[i]) begin
                    n_rp[i] = '0;
                end
            end
        end else if (i_exec) begin
            case (i_op)
                mrrb_pkg::OP_PUSH_BYTE, mrrb_pkg::OP_PUSH_HALF: begin
                    if (o_info.push_ok) begin
                        n_w = o_info.push_two ? w2 : w1;
                    end
                end
                mrrb_pkg::OP_PULL_BYTE, mrrb_pkg::OP_PULL_HALF, mrrb_pkg::OP_SKIP: begin
                    if (rd_ok) begin
                        p_after = p_adv;
                        for (int i = 0; i < READERS; i++) begin
                            if (RW'(i) == idx) begin
                                n_rp[i] = p_adv;
                            end
                        end
                    end
                end
                mrrb_pkg::OP_OPEN: begin
                    if (rd_valid && !cur_open) begin
                        p_after = r_w;
                        for (int i = 0; i < READERS; i++) begin
                            if (RW'(i) == idx) begin
                                n_open[i] = 1'b1;
                                n_rp[i]   = r_w;
                            end
                        end
                    end
                end
                mrrb_pkg::OP_CLOSE: begin
                    if (rd_valid) begin
                        p_after = '0;
                        for (int i = 0; i < READERS; i++) begin
                            if (RW'(i) == idx) begin
                                n_open[i] = 1'b0;
                                n_rp[i]   = '0;
                            end
                        end
                    end
                end
                mrrb_pkg::OP_CLEAR: begin
                    p_after = '0;
                    n_w     = '0;
                    for (int i = 0; i < READERS; i++) begin
                        if (r_open[i]) begin
                            n_rp[i] = '0;
                        end
                    end
                end
                default: begin
                    p_after = cur_p;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= '0;
            r_open <= '0;
            for (int i = 0; i < READERS; i++) begin
                r_rp[i] <= '0;
            end
        end else begin
            r_w    <= n_w;
            r_open <= n_open;
            for (int i = 0; i < READERS; i++) begin
                r_rp[i] <= n_rp[i];
            end
        end
    end

    // pulls read their data from the old position, header follows it
    assign o_rd_base  = o_info.pull_ok ? cur_p : p_after;
    assign o_wr_addr0 = r_w;
    assign o_wr_addr1 = w1;

    assign o_fill_full     = cur_fill;
    assign o_view.fill     = cur_fill[11:0];
    assign o_view.max_fill = max_fill[11:0];
    assign o_view.is_open  = cur_open;

endmodule

FILE: src/multi_reader_ring_buffer.sv
// Sequence: an accepted item passes through an execute state, an extra write state for the
//   second byte of a stored halfword push, and the read states RD0, RD1 and RD2, whose paired
//   reads from the two ring memory read ports fetch six bytes for read data and the chunk
//   header; the result is then registered from the done state. The input stalls from acceptance
//   until the result is loaded, and a stalled result holds the input until it is taken.
// Reset: synchronous, active low; clears write and read offsets, closes all readers and
//   sets ring_bytes to 4096. The ring memory is not cleared.
`include "assert_macros.svh"

module multi_reader_ring_buffer #(
    parameter int RING_DEPTH = 4096,
    parameter int READERS    = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_op,
    input  logic [1:0]  i_reader,
    input  logic [15:0] i_data,
    input  logic [11:0] i_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_read_data,
    output logic [11:0] o_fill,
    output logic [11:0] o_max_fill,
    output logic        o_reader_open,
    output logic        o_chunk_ready,
    output logic [15:0] o_chunk_id,
    output logic [15:0] o_chunk_len,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int BW = AW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_WR2  = 3'd2;
    localparam logic [2:0] S_RD0  = 3'd3;
    localparam logic [2:0] S_RD1  = 3'd4;
    localparam logic [2:0] S_RD2  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    function automatic logic [BW-1:0] size_of(input logic [12:0] v);
        logic [31:0] t;
        t = {19'd0, v & 13'h1FFE};
        if (t < 32'd4) begin
            t = 32'd4;
        end
        if (t > 32'(RING_DEPTH)) begin
            t = 32'(RING_DEPTH) & ~32'd1;
        end
        return t[BW-1:0];
    endfunction

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [3:0]            r_op;
    logic [1:0]            r_reader;
    logic [15:0]           r_data;
    logic [11:0]           r_count;
    logic [12:0]           r_ring_bytes;
    logic [BW-1:0]         r_size;
    mrrb_pkg::t_exec_info  r_info;
    logic [AW-1:0]         r_waddr1;
    logic [AW-1:0]         r_ra;
    logic [7:0]            r_byte [4];

    logic                  in_accept;
    logic                  cfg_we;
    logic                  out_load;
    mrrb_pkg::t_exec_info  exec_info;
    mrrb_pkg::t_view       view;
    logic [AW-1:0]         wr_addr0;
    logic [AW-1:0]         wr_addr1;
    logic [AW-1:0]         rd_base;
    logic [AW-1:0]         fill_full;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [7:0]            ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         raddr_b;
    logic [7:0]            rdata_a;
    logic [7:0]            rdata_b;
    logic [7:0]            hb [6];
    logic [15:0]           hdr_id;
    logic [15:0]           hdr_len;
    logic                  hdr_ok;
    logic                  exec_over;
    logic                  wr_in_ring;
    logic                  fill_in_cap;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_load   = (r_state == S_DONE) && (!o_out_valid || !i_out_stall);

    assign cfg_we = psel && penable && pwrite && pready && (paddr == mrrb_pkg::REG_RING_BYTES);
    assign pready = 1'b1;
    assign prdata = (paddr == mrrb_pkg::REG_RING_BYTES) ? {19'd0, r_ring_bytes} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_bytes <= mrrb_pkg::RING_BYTES_RST;
            r_size       <= size_of(mrrb_pkg::RING_BYTES_RST);
        end else if (cfg_we) begin
            r_ring_bytes <= pwdata[12:0];
            r_size       <= size_of(pwdata[12:0]);
        end
    end

    mrrb_state #(
        .RING_DEPTH (RING_DEPTH),
        .READERS    (READERS)
    ) u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_size      (r_size),
        .i_exec      (r_state == S_EXEC),
        .i_empty     (cfg_we),
        .i_op        (r_op),
        .i_reader    (r_reader),
        .i_count     (r_count),
        .o_info      (exec_info),
        .o_wr_addr0  (wr_addr0),
        .o_wr_addr1  (wr_addr1),
        .o_rd_base   (rd_base),
        .o_view      (view),
        .o_fill_full (fill_full)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = wr_addr0;
        ram_wdata = r_data[7:0];
        if (r_state == S_EXEC) begin
            ram_we = exec_info.push_ok;
        end else if (r_state == S_WR2) begin
            ram_we    = 1'b1;
            ram_waddr = r_waddr1;
            ram_wdata = r_data[15:8];
        end
    end

    assign ram_re  = (r_state == S_RD0) || (r_state == S_RD1) || (r_state == S_RD2);
    assign raddr_b = AW'(mrrb_pkg::ring_inc(mrrb_pkg::t_ptr'(r_ra), mrrb_pkg::t_ptr'(r_size)));

    mrrb_ram #(
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_re      (ram_re),
        .i_raddr_a (r_ra),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = (exec_info.push_ok && exec_info.push_two) ? S_WR2 : S_RD0;
            end
            S_WR2:  n_state = S_RD0;
            S_RD0:  n_state = S_RD1;
            S_RD1:  n_state = S_RD2;
            S_RD2:  n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op     <= mrrb_pkg::OP_QUERY;
            r_reader <= '0;
        end else if (in_accept) begin
            r_op     <= i_op;
            r_reader <= i_reader;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_data   <= i_data;
            r_count  <= i_count;
        end
        if (r_state == S_EXEC) begin
            r_info   <= exec_info;
            r_waddr1 <= wr_addr1;
            r_ra     <= rd_base;
        end else if (ram_re) begin
            r_ra <= AW'(mrrb_pkg::ring_inc(mrrb_pkg::t_ptr'(raddr_b), mrrb_pkg::t_ptr'(r_size)));
        end
        if (r_state == S_RD1) begin
            r_byte[0] <= rdata_a;
            r_byte[1] <= rdata_b;
        end
        if (r_state == S_RD2) begin
            r_byte[2] <= rdata_a;
            r_byte[3] <= rdata_b;
        end
    end

    // six consecutive bytes from the read base; last pair held at the memory output
    always_comb begin
        hb[0] = r_byte[0];
        hb[1] = r_byte[1];
        hb[2] = r_byte[2];
        hb[3] = r_byte[3];
        hb[4] = rdata_a;
        hb[5] = rdata_b;
        if (!r_info.pull_ok) begin
            hdr_id  = {hb[1], hb[0]};
            hdr_len = {hb[3], hb[2]};
        end else if (!r_info.pull_half) begin
            hdr_id  = {hb[2], hb[1]};
            hdr_len = {hb[4], hb[3]};
        end else begin
            hdr_id  = {hb[3], hb[2]};
            hdr_len = {hb[5], hb[4]};
        end
        hdr_ok = (BW'(fill_full) >= BW'(4));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_status      <= r_info.status;
            o_fill        <= view.fill;
            o_max_fill    <= view.max_fill;
            o_reader_open <= view.is_open;
            if (!r_info.pull_ok) begin
                o_read_data <= 16'd0;
            end else if (r_info.pull_half) begin
                o_read_data <= {hb[1], hb[0]};
            end else begin
                o_read_data <= {8'd0, hb[0]};
            end
            if (hdr_ok) begin
                o_chunk_id    <= hdr_id;
                o_chunk_len   <= hdr_len;
                o_chunk_ready <= (32'(fill_full) >= (32'(hdr_len) + 32'd4));
            end else begin
                o_chunk_id    <= 16'd0;
                o_chunk_len   <= 16'd0;
                o_chunk_ready <= 1'b0;
            end
        end
    end

    assign exec_over   = (r_state == S_EXEC) && (exec_info.status == mrrb_pkg::ST_OVER);
    assign wr_in_ring  = ({1'b0, ram_waddr} < r_size);
    assign fill_in_cap = ((BW'(fill_full) + BW'(2)) <= r_size);

    `ASSERT_IMPLY(a_no_write_on_overflow, exec_over, !ram_we, "ring written by a refused push")
    `ASSERT_IMPLY(a_write_inside_ring, ram_we, wr_in_ring, "ring write beyond ring size")
    `ASSERT_ALWAYS(a_fill_bound, fill_in_cap, "reader fill exceeds capacity")

endmodule
